@@ hw/rtl/c7mac_pkg.sv @@
package c7mac_pkg;

  localparam int KERNEL_SIZE = 7;
  localparam int ROW_PIXELS  = 8;
  localparam int PX_W        = 16;
  localparam int COEF_W      = 16;
  localparam int SUM_W       = 32;
  localparam int IDX_W       = 6;
  localparam int ROW_W       = $clog2(KERNEL_SIZE);
  localparam int COEF_COUNT  = KERNEL_SIZE * KERNEL_SIZE;
  localparam int HALF        = (KERNEL_SIZE + 1) / 2;

  // queue between front and back
  localparam int MQ_DEPTH = 2;
  localparam int MQ_PTR_W = $clog2(MQ_DEPTH);
  localparam int MQ_CNT_W = $clog2(MQ_DEPTH + 1);

  // result queue at the output
  localparam int OQ_DEPTH = 4;
  localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
  localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

  localparam logic CMD_COEF = 1'b0;
  localparam logic CMD_ROW  = 1'b1;

  typedef logic signed [PX_W-1:0]   px_t;
  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic signed [SUM_W-1:0]  sum_t;

  // one row request handed from front to back
  typedef struct packed {
    logic                          last;
    px_t   [ROW_PIXELS-1:0]        pix;
    coef_t [KERNEL_SIZE-1:0]       coef;
  } row_req_t;

  function automatic logic [ROW_W-1:0] idx_row(input logic [IDX_W-1:0] idx);
    logic [ROW_W-1:0] row;
    row = '0;
    for (int r = 1; r < KERNEL_SIZE; r++) begin
      if (idx >= IDX_W'(r * KERNEL_SIZE)) begin
        row = ROW_W'(r);
      end
    end
    return row;
  endfunction

  function automatic logic [ROW_W-1:0] idx_col(input logic [IDX_W-1:0] idx);
    logic [IDX_W-1:0] base;
    base = IDX_W'(idx_row(idx)) * IDX_W'(KERNEL_SIZE);
    return ROW_W'(idx - base);
  endfunction

  // absolute value, most negative value saturates to the maximum
  function automatic sum_t sat_abs(input sum_t v);
    sum_t res;
    if (v == {1'b1, {(SUM_W-1){1'b0}}}) begin
      res = {1'b0, {(SUM_W-1){1'b1}}};
    end else if (v[SUM_W-1]) begin
      res = -v;
    end else begin
      res = v;
    end
    return res;
  endfunction

endpackage

@@ hw/rtl/conv7x7_two_pixel_mac.sv @@
// 7x7 correlation of signed 16-bit pixels for two adjacent output pixels.
//
// Input queue side: push/full. An item with cmd 0 writes coef_value into
// the coefficient store at coef_index (row*7+column, indexes of 49 and up
// are dropped). An item with cmd 1 brings one window row pix0..pix7; pix0..6
// feed the left sum and pix1..7 the right sum.
// Result queue side: empty/pop. After every seventh row one result
// (sum_left, sum_right) is queued, 32-bit wrapping sums, or their saturated
// absolute values when abs_mode is set.
// Config: abs_mode is written when cfg_valid and cfg_ready are high.
//
// Throughput: one item per cycle while full is low. After its last row is
// accepted, a result passes the request queue, product stage, partial sum
// stage, accumulator and result queue write before it can be popped.
// Reset clears the coefficients, accumulators, row count, abs_mode and both
// queues. When the receiver stalls, results collect in a four-entry queue;
// once its four slots are taken by queued or pending results, the next last
// row holds at the head of the two-entry request queue, requests behind it wait there, and full rises.
module conv7x7_two_pixel_mac
  import c7mac_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic               cmd,
  input  logic [IDX_W-1:0]   coef_index,
  input  logic signed [15:0] coef_value,
  input  logic signed [15:0] pix0,
  input  logic signed [15:0] pix1,
  input  logic signed [15:0] pix2,
  input  logic signed [15:0] pix3,
  input  logic signed [15:0] pix4,
  input  logic signed [15:0] pix5,
  input  logic signed [15:0] pix6,
  input  logic signed [15:0] pix7,
  output logic               empty,
  input  logic               pop,
  output logic signed [31:0] sum_left,
  output logic signed [31:0] sum_right,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               abs_mode
);

  px_t [ROW_PIXELS-1:0] pix_row;
  logic                 mq_push;
  row_req_t             mq_wdata;
  row_req_t             mq_rdata;
  logic                 mq_pop;
  logic                 mq_empty;

  assign pix_row = {pix7, pix6, pix5, pix4, pix3, pix2, pix1, pix0};

  c7mac_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .cmd        (cmd),
    .coef_index (coef_index),
    .coef_value (coef_value),
    .pix_row    (pix_row),
    .mq_push    (mq_push),
    .mq_data    (mq_wdata)
  );

  c7mac_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (mq_push),
    .wr_data (mq_wdata),
    .full    (full),
    .rd_en   (mq_pop),
    .rd_data (mq_rdata),
    .empty   (mq_empty)
  );

  c7mac_back u_back (
    .clk       (clk),
    .rst       (rst),
    .mq_empty  (mq_empty),
    .mq_data   (mq_rdata),
    .mq_pop    (mq_pop),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .abs_mode  (abs_mode),
    .pop       (pop),
    .empty     (empty),
    .sum_left  (sum_left),
    .sum_right (sum_right)
  );

endmodule

@@ hw/rtl/c7mac_queue.sv @@
module c7mac_queue
  import c7mac_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     wr_en,
  input  row_req_t wr_data,
  output logic     full,
  input  logic     rd_en,
  output row_req_t rd_data,
  output logic     empty
);

  row_req_t            mem [MQ_DEPTH];
  logic [MQ_PTR_W-1:0] wr_ptr;
  logic [MQ_PTR_W-1:0] rd_ptr;
  logic [MQ_CNT_W-1:0] count;
  logic                do_wr;
  logic                do_rd;

  assign full    = (count == MQ_CNT_W'(MQ_DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == MQ_PTR_W'(MQ_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == MQ_PTR_W'(MQ_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + MQ_CNT_W'(do_wr) - MQ_CNT_W'(do_rd);
    end
  end

endmodule

@@ hw/rtl/c7mac_front.sv @@
module c7mac_front
  import c7mac_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  logic                   full,
  input  logic                   cmd,
  input  logic [IDX_W-1:0]       coef_index,
  input  coef_t                  coef_value,
  input  px_t [ROW_PIXELS-1:0]   pix_row,
  output logic                   mq_push,
  output row_req_t               mq_data
);

  logic                    accept;
  logic                    coef_wr;
  logic                    row_acc;
  logic                    last_row;
  logic [ROW_W-1:0]        row_cnt;
  logic [ROW_W-1:0]        wr_row;
  logic [ROW_W-1:0]        wr_col;
  coef_t [KERNEL_SIZE-1:0] rd_coef;

  assign accept   = push && !full;
  assign coef_wr  = accept && (cmd == CMD_COEF) && (coef_index < IDX_W'(COEF_COUNT));
  assign row_acc  = accept && (cmd == CMD_ROW);
  assign last_row = (row_cnt == ROW_W'(KERNEL_SIZE - 1));
  assign wr_row   = idx_row(coef_index);
  assign wr_col   = idx_col(coef_index);

  // one small store per kernel column, addressed by kernel row
  for (genvar c = 0; c < KERNEL_SIZE; c++) begin : g_col
    coef_t col_mem [KERNEL_SIZE];

    always_ff @(posedge clk) begin
      if (rst) begin
        for (int r = 0; r < KERNEL_SIZE; r++) begin
          col_mem[r] <= '0;
        end
      end else if (coef_wr && (wr_col == ROW_W'(c))) begin
        col_mem[wr_row] <= coef_value;
      end
    end

    assign rd_coef[c] = col_mem[row_cnt];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_cnt <= '0;
    end else if (row_acc) begin
      row_cnt <= last_row ? '0 : row_cnt + 1'b1;
    end
  end

  // coefficients are read at acceptance, so a later write cannot overtake
  assign mq_push      = row_acc;
  assign mq_data.last = last_row;
  assign mq_data.pix  = pix_row;
  assign mq_data.coef = rd_coef;

endmodule

@@ hw/rtl/c7mac_back.sv @@
module c7mac_back
  import c7mac_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     mq_empty,
  input  row_req_t mq_data,
  output logic     mq_pop,
  input  logic     cfg_valid,
  output logic     cfg_ready,
  input  logic     abs_mode,
  input  logic     pop,
  output logic     empty,
  output sum_t     sum_left,
  output sum_t     sum_right
);

  logic                abs_q;
  logic [OQ_CNT_W-1:0] res_cnt;
  logic                issue;
  logic                out_pop;

  logic                v1;
  logic                last1;
  sum_t                prod_l [KERNEL_SIZE];
  sum_t                prod_r [KERNEL_SIZE];

  logic                v2;
  logic                last2;
  sum_t                sl0, sl1, sr0, sr1;
  sum_t                part_l0, part_l1, part_r0, part_r1;

  sum_t                acc_l, acc_r;
  sum_t                tot_l, tot_r;
  logic                fin;
  sum_t                fin_l, fin_r;

  sum_t                oq_l [OQ_DEPTH];
  sum_t                oq_r [OQ_DEPTH];
  logic [OQ_PTR_W-1:0] oq_wr;
  logic [OQ_PTR_W-1:0] oq_rd;
  logic [OQ_CNT_W-1:0] oq_cnt;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      abs_q <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      abs_q <= abs_mode;
    end
  end

  // a window's last row issues only with a result slot reserved
  assign out_pop = pop && !empty;
  assign issue   = !mq_empty && (!mq_data.last || (res_cnt < OQ_CNT_W'(OQ_DEPTH)));
  assign mq_pop  = issue;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_cnt <= '0;
    end else begin
      res_cnt <= res_cnt + OQ_CNT_W'(issue && mq_data.last) - OQ_CNT_W'(out_pop);
    end
  end

  // stage 1: fourteen products
  always_ff @(posedge clk) begin
    if (rst) begin
      v1    <= 1'b0;
      last1 <= 1'b0;
    end else begin
      v1    <= issue;
      last1 <= issue && mq_data.last;
    end
  end

  for (genvar c = 0; c < KERNEL_SIZE; c++) begin : g_mul
    always_ff @(posedge clk) begin
      if (issue) begin
        prod_l[c] <= $signed(mq_data.coef[c]) * $signed(mq_data.pix[c]);
      end
    end
    if (c + 1 < ROW_PIXELS) begin : g_right
      always_ff @(posedge clk) begin
        if (issue) begin
          prod_r[c] <= $signed(mq_data.coef[c]) * $signed(mq_data.pix[c+1]);
        end
      end
    end else begin : g_none
      always_ff @(posedge clk) begin
        prod_r[c] <= '0;
      end
    end
  end

  // stage 2: two partial sums per side
  always_comb begin
    sl0 = '0;
    sl1 = '0;
    sr0 = '0;
    sr1 = '0;
    for (int c = 0; c < KERNEL_SIZE; c++) begin
      if (c < HALF) begin
        sl0 = sl0 + prod_l[c];
        sr0 = sr0 + prod_r[c];
      end else begin
        sl1 = sl1 + prod_l[c];
        sr1 = sr1 + prod_r[c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2    <= 1'b0;
      last2 <= 1'b0;
    end else begin
      v2    <= v1;
      last2 <= last1;
    end
  end

  always_ff @(posedge clk) begin
    if (v1) begin
      part_l0 <= sl0;
      part_l1 <= sl1;
      part_r0 <= sr0;
      part_r1 <= sr1;
    end
  end

  // stage 3: accumulate, restart after the last row
  assign tot_l = acc_l + part_l0 + part_l1;
  assign tot_r = acc_r + part_r0 + part_r1;

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_l <= '0;
      acc_r <= '0;
      fin   <= 1'b0;
    end else begin
      fin <= v2 && last2;
      if (v2) begin
        acc_l <= last2 ? '0 : tot_l;
        acc_r <= last2 ? '0 : tot_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (v2 && last2) begin
      fin_l <= tot_l;
      fin_r <= tot_r;
    end
  end

  // stage 4: result queue
  always_ff @(posedge clk) begin
    if (fin) begin
      oq_l[oq_wr] <= abs_q ? sat_abs(fin_l) : fin_l;
      oq_r[oq_wr] <= abs_q ? sat_abs(fin_r) : fin_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      oq_wr  <= '0;
      oq_rd  <= '0;
      oq_cnt <= '0;
    end else begin
      if (fin) begin
        oq_wr <= (oq_wr == OQ_PTR_W'(OQ_DEPTH - 1)) ? '0 : oq_wr + 1'b1;
      end
      if (out_pop) begin
        oq_rd <= (oq_rd == OQ_PTR_W'(OQ_DEPTH - 1)) ? '0 : oq_rd + 1'b1;
      end
      oq_cnt <= oq_cnt + OQ_CNT_W'(fin) - OQ_CNT_W'(out_pop);
    end
  end

  assign empty     = (oq_cnt == '0);
  assign sum_left  = oq_l[oq_rd];
  assign sum_right = oq_r[oq_rd];

endmodule

@@ hw/rtl/c7mac_checker.sv @@
module c7mac_checker
  import c7mac_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             push,
  input logic             full,
  input logic             pop,
  input logic             empty,
  input logic [SUM_W-1:0] sum_left,
  input logic [SUM_W-1:0] sum_right
);

  // both queues come out of reset empty
  a_reset_state: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("queues not empty after reset");

  // the request queue only fills through a push
  a_full_needs_push: assert property (@(posedge clk) disable iff (rst)
    !full && !push |=> !full)
    else $error("full rose without a request");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty)
    else $error("waiting result dropped");

  a_result_stable: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> $stable(sum_left) && $stable(sum_right))
    else $error("waiting result changed");

endmodule

bind conv7x7_two_pixel_mac c7mac_checker u_chk (
  .clk       (clk),
  .rst       (rst),
  .push      (push),
  .full      (full),
  .pop       (pop),
  .empty     (empty),
  .sum_left  (sum_left),
  .sum_right (sum_right)
);
